// ===== rtl/vpp_pkg.sv =====
// Shared types, constants and helpers for the vertex perspective projection pipeline.
`default_nettype none
package vpp_pkg;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        CFG_CAM_POS = 3'd0,
        CFG_COL0    = 3'd1,
        CFG_COL1    = 3'd2,
        CFG_COL2    = 3'd3,
        CFG_FOCAL   = 3'd4,
        CFG_SCALE   = 3'd5,
        CFG_WIDTH   = 3'd6,
        CFG_HEIGHT  = 3'd7
    } t_cfg_idx;

    localparam int CFG_W   = 48;
    localparam int CAM_W   = 21;                // camera-space component, Q.8
    localparam int FS_W    = 40;                // focal * scale
    localparam int QW      = 33;                // quotient bits kept before clamping
    localparam int BW      = CAM_W;             // divisor magnitude
    localparam int AW      = BW + QW;           // dividend magnitude after the /256
    localparam int LAT     = 40;                // start to strobe, in cycles

    localparam logic [47:0] COL0_RST = 48'h0000_0000_4000;
    localparam logic [47:0] COL1_RST = 48'h0000_4000_0000;
    localparam logic [47:0] COL2_RST = 48'h4000_0000_0000;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Texture words ride alongside the arithmetic
    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic        tv;
    } t_tex_side;

    // Sign and exception flags from the numerator stage
    typedef struct packed {
        logic                    neg_x;   // numerator for x below zero
        logic                    neg_y;
        logic                    qs_x;    // quotient for x is negative
        logic                    qs_y;
        logic                    clamp_x; // quotient too large, force saturation
        logic                    clamp_y;
        logic                    zero;    // depth is zero
        logic signed [CAM_W-1:0] z;
    } t_sgn;

    typedef struct packed {
        t_tex_side tex;
        t_sgn      sgn;
    } t_div_side;

    // Pick one signed Q entry of a packed 48-bit register
    function automatic logic signed [15:0] field16(input logic [47:0] w, input logic [1:0] i);
        field16 = w[16*i +: 16];
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > 36'sh0_7FFF_FFFF)
            sat32 = SAT_MAX;
        else if (x < -36'sh0_8000_0000)
            sat32 = SAT_MIN;
        else
            sat32 = x[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vpp_xform.sv =====
// Camera translation and orientation matrix product, three register stages.
`default_nettype none
module vpp_xform #(
    parameter int SW = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [15:0]                  i_px,
    input  wire logic signed [15:0]                  i_py,
    input  wire logic signed [15:0]                  i_pz,
    input  wire logic [47:0]                         i_cam_pos,
    input  wire logic [47:0]                         i_col0,
    input  wire logic [47:0]                         i_col1,
    input  wire logic [47:0]                         i_col2,
    input  wire logic [SW-1:0]                       i_side,
    output logic                                     o_valid,
    output logic signed [vpp_pkg::CAM_W-1:0]         o_cx,
    output logic signed [vpp_pkg::CAM_W-1:0]         o_cy,
    output logic signed [vpp_pkg::CAM_W-1:0]         o_cz,
    output logic [SW-1:0]                            o_side
);
    logic signed [16:0] n_d [3];
    logic signed [16:0] r_d [3];
    logic signed [32:0] r_p [3][3];
    logic signed [34:0] n_acc [3];
    logic signed [vpp_pkg::CAM_W-1:0] r_c [3];
    logic        r_v1, r_v2, r_v3;
    logic [SW-1:0] r_s1, r_s2, r_s3;

    // Subtract the camera position
    always_comb begin
        n_d[0] = 17'(i_px) - 17'(vpp_pkg::field16(i_cam_pos, 2'd0));
        n_d[1] = 17'(i_py) - 17'(vpp_pkg::field16(i_cam_pos, 2'd1));
        n_d[2] = 17'(i_pz) - 17'(vpp_pkg::field16(i_cam_pos, 2'd2));
    end

    // Sum each column's products, floor the Q2.14 fraction away
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_acc[j] = 35'(r_p[j][0]) + 35'(r_p[j][1]) + 35'(r_p[j][2]);
        end
    end

    // Data path registers
    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        for (int i = 0; i < 3; i++) begin
            r_p[0][i] <= r_d[i] * vpp_pkg::field16(i_col0, 2'(i));
            r_p[1][i] <= r_d[i] * vpp_pkg::field16(i_col1, 2'(i));
            r_p[2][i] <= r_d[i] * vpp_pkg::field16(i_col2, 2'(i));
        end
        for (int j = 0; j < 3; j++) begin
            r_c[j] <= n_acc[j][34:14];
        end
        r_s1 <= i_side;
        r_s2 <= r_s1;
        r_s3 <= r_s2;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_cx    = r_c[0];
    assign o_cy    = r_c[1];
    assign o_cz    = r_c[2];
    assign o_side  = r_s3;
endmodule
`default_nettype wire

// ===== rtl/vpp_numer.sv =====
// Numerator build (focal * scale * coordinate) and sign split, three register stages.
`default_nettype none
module vpp_numer #(
    parameter int SW = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [vpp_pkg::CAM_W-1:0]    i_cx,
    input  wire logic signed [vpp_pkg::CAM_W-1:0]    i_cy,
    input  wire logic signed [vpp_pkg::CAM_W-1:0]    i_cz,
    input  wire logic [vpp_pkg::FS_W-1:0]            i_fs,
    input  wire logic [SW-1:0]                       i_side,
    output logic                                     o_valid,
    output logic [vpp_pkg::AW-1:0]                   o_ax,
    output logic [vpp_pkg::AW-1:0]                   o_ay,
    output logic [vpp_pkg::BW-1:0]                   o_b,
    output vpp_pkg::t_sgn                            o_sgn,
    output logic [SW-1:0]                            o_side
);
    logic signed [21:0] n_nx, n_ny;
    logic signed [42:0] r_pxl, r_pxh, r_pyl, r_pyh;
    logic signed [vpp_pkg::CAM_W-1:0] r_z4, r_z5;
    logic signed [61:0] r_numx, r_numy;
    logic [61:0] n_magx, n_magy;
    logic [vpp_pkg::BW-1:0] n_b;
    logic [vpp_pkg::AW-1:0] r_ax, r_ay;
    logic [vpp_pkg::BW-1:0] r_b;
    vpp_pkg::t_sgn n_sgn, r_sgn;
    logic r_v4, r_v5, r_v6;
    logic [SW-1:0] r_s4, r_s5, r_s6;

    // Negate x for the screen flip
    assign n_nx = -22'(i_cx);
    assign n_ny = 22'(i_cy);

    // Magnitudes and sign flags
    always_comb begin
        n_magx = r_numx[61] ? 62'(-r_numx) : 62'(r_numx);
        n_magy = r_numy[61] ? 62'(-r_numy) : 62'(r_numy);
        n_b    = r_z5[vpp_pkg::CAM_W-1] ? vpp_pkg::BW'(-r_z5) : vpp_pkg::BW'(r_z5);
        n_sgn.neg_x   = r_numx[61];
        n_sgn.neg_y   = r_numy[61];
        n_sgn.qs_x    = r_numx[61] ^ r_z5[vpp_pkg::CAM_W-1];
        n_sgn.qs_y    = r_numy[61] ^ r_z5[vpp_pkg::CAM_W-1];
        n_sgn.clamp_x = n_magx[61:8] >= {n_b, {vpp_pkg::QW{1'b0}}};
        n_sgn.clamp_y = n_magy[61:8] >= {n_b, {vpp_pkg::QW{1'b0}}};
        n_sgn.zero    = (r_z5 == '0);
        n_sgn.z       = r_z5;
    end

    // Data path registers
    always_ff @(posedge i_clk) begin
        r_pxl  <= $signed({1'b0, i_fs[19:0]}) * n_nx;
        r_pxh  <= $signed({1'b0, i_fs[39:20]}) * n_nx;
        r_pyl  <= $signed({1'b0, i_fs[19:0]}) * n_ny;
        r_pyh  <= $signed({1'b0, i_fs[39:20]}) * n_ny;
        r_z4   <= i_cz;
        r_numx <= 62'(r_pxl) + (62'(r_pxh) <<< 20);
        r_numy <= 62'(r_pyl) + (62'(r_pyh) <<< 20);
        r_z5   <= r_z4;
        r_ax   <= n_magx[61:8];
        r_ay   <= n_magy[61:8];
        r_b    <= n_b;
        r_sgn  <= n_sgn;
        r_s4   <= i_side;
        r_s5   <= r_s4;
        r_s6   <= r_s5;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_valid = r_v6;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_b     = r_b;
    assign o_sgn   = r_sgn;
    assign o_side  = r_s6;
endmodule
`default_nettype wire

// ===== rtl/vpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two dividends share a divisor.
`default_nettype none
module vpp_div #(
    parameter int QW = vpp_pkg::QW,
    parameter int BW = vpp_pkg::BW,
    parameter int SW = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [BW+QW-1:0]    i_ax,
    input  wire logic [BW+QW-1:0]    i_ay,
    input  wire logic [BW-1:0]       i_b,
    input  wire logic [SW-1:0]       i_side,
    output logic                     o_valid,
    output logic [QW-1:0]            o_qx,
    output logic [QW-1:0]            o_qy,
    output logic [SW-1:0]            o_side
);
    localparam int AW = BW + QW;

    logic [AW-1:0] r_ax [1:QW-1];
    logic [AW-1:0] r_ay [1:QW-1];
    logic [BW-1:0] r_b  [1:QW-1];
    logic [QW-1:0] r_qx [1:QW];
    logic [QW-1:0] r_qy [1:QW];
    logic [SW-1:0] r_s  [1:QW];
    logic          r_v  [1:QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [AW-1:0] w_ax, w_ay, w_dv;
        logic [BW-1:0] w_b;
        logic [QW-1:0] w_qx, w_qy;
        logic [SW-1:0] w_s;
        logic          w_v, w_gx, w_gy;

        if (s == 0) begin : g_in
            assign w_ax = i_ax;
            assign w_ay = i_ay;
            assign w_b  = i_b;
            assign w_qx = '0;
            assign w_qy = '0;
            assign w_s  = i_side;
            assign w_v  = i_valid;
        end else begin : g_mid
            assign w_ax = r_ax[s];
            assign w_ay = r_ay[s];
            assign w_b  = r_b[s];
            assign w_qx = r_qx[s];
            assign w_qy = r_qy[s];
            assign w_s  = r_s[s];
            assign w_v  = r_v[s];
        end

        // Trial subtract of the shifted divisor
        assign w_dv = {{QW{1'b0}}, w_b} << (QW - 1 - s);
        assign w_gx = (w_ax >= w_dv);
        assign w_gy = (w_ay >= w_dv);

        if (s < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_ax[s+1] <= w_gx ? w_ax - w_dv : w_ax;
                r_ay[s+1] <= w_gy ? w_ay - w_dv : w_ay;
                r_b[s+1]  <= w_b;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qx[s+1] <= {w_qx[QW-2:0], w_gx};
            r_qy[s+1] <= {w_qy[QW-2:0], w_gy};
            r_s[s+1]  <= w_s;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= w_v;
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_qx    = r_qx[QW];
    assign o_qy    = r_qy[QW];
    assign o_side  = r_s[QW];
endmodule
`default_nettype wire

// ===== rtl/vertex_perspective_projection.sv =====
// Top level of the pinhole camera vertex projection pipeline.
// Usage: drive a vertex (i_point_x/y/z, Q8.8) and texture pair (i_tex_u/v) with
// start high; the word is taken at that clock edge. busy is always low, so a new
// vertex may enter on every cycle.
// The result word appears on o_screen_x, o_screen_y, o_depth, o_tex_out_u/v,
// o_tex_valid and o_divide_error, marked by o_valid for exactly one cycle.
// Throughput is one vertex per cycle, set by a fully pipelined datapath:
// 3 stages of translate and rotate, 3 stages building the numerator,
// 33 stages of restoring division (one quotient bit each) and one output stage.
// The receiver cannot stall; results are shown once and are gone next cycle.
// Configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes one register per
// cycle; write only while the pipeline is empty. The focal * scale product is
// refreshed in the cycle after a write, well before a new word reaches the numerator.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the camera at
// the origin, identity orientation, unit focal length and scale, 640 x 480.
`default_nettype none
module vertex_perspective_projection (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_point_x,
    input  wire logic signed [15:0] i_point_y,
    input  wire logic signed [15:0] i_point_z,
    input  wire logic signed [15:0] i_tex_u,
    input  wire logic signed [15:0] i_tex_v,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [47:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [31:0]      o_screen_x,
    output logic signed [31:0]      o_screen_y,
    output logic signed [31:0]      o_depth,
    output logic signed [15:0]      o_tex_out_u,
    output logic signed [15:0]      o_tex_out_v,
    output logic                    o_tex_valid,
    output logic                    o_divide_error
);
    localparam int TSW = $bits(vpp_pkg::t_tex_side);
    localparam int DSW = $bits(vpp_pkg::t_div_side);

    logic [47:0] r_cam_pos, r_col0, r_col1, r_col2;
    logic [15:0] r_focal;
    logic [23:0] r_scale;
    logic [11:0] r_width, r_height;
    logic [vpp_pkg::FS_W-1:0] r_fs;

    vpp_pkg::t_tex_side n_tex, x_tex, m_tex;
    vpp_pkg::t_div_side d_side_in, d_side_out;
    vpp_pkg::t_sgn m_sgn;
    logic x_valid, m_valid, d_valid;
    logic signed [vpp_pkg::CAM_W-1:0] x_cx, x_cy, x_cz;
    logic [vpp_pkg::AW-1:0] m_ax, m_ay;
    logic [vpp_pkg::BW-1:0] m_b;
    logic [vpp_pkg::QW-1:0] d_qx, d_qy, n_magx, n_magy;
    logic signed [35:0] n_sumx, n_sumy;
    logic signed [31:0] n_sx, n_sy;

    logic r_valid;
    logic signed [31:0] r_sx, r_sy, r_depth;
    logic [15:0] r_tu, r_tv;
    logic r_tvld, r_err;

    assign busy = 1'b0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos <= '0;
            r_col0    <= vpp_pkg::COL0_RST;
            r_col1    <= vpp_pkg::COL1_RST;
            r_col2    <= vpp_pkg::COL2_RST;
            r_focal   <= 16'd256;
            r_scale   <= 24'd256;
            r_width   <= 12'd640;
            r_height  <= 12'd480;
        end else if (i_cfg_we) begin
            case (vpp_pkg::t_cfg_idx'(i_cfg_idx))
                vpp_pkg::CFG_CAM_POS: r_cam_pos <= i_cfg_data;
                vpp_pkg::CFG_COL0:    r_col0    <= i_cfg_data;
                vpp_pkg::CFG_COL1:    r_col1    <= i_cfg_data;
                vpp_pkg::CFG_COL2:    r_col2    <= i_cfg_data;
                vpp_pkg::CFG_FOCAL:   r_focal   <= i_cfg_data[15:0];
                vpp_pkg::CFG_SCALE:   r_scale   <= i_cfg_data[23:0];
                vpp_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[11:0];
                vpp_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Precompute focal * scale from the static registers
    always_ff @(posedge i_clk) begin
        r_fs <= r_focal * r_scale;
    end

    // Tag the texture word
    always_comb begin
        n_tex.u  = i_tex_u;
        n_tex.v  = i_tex_v;
        n_tex.tv = !i_tex_u[15] && !i_tex_v[15];
    end

    vpp_xform #(.SW(TSW)) u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_px      (i_point_x),
        .i_py      (i_point_y),
        .i_pz      (i_point_z),
        .i_cam_pos (r_cam_pos),
        .i_col0    (r_col0),
        .i_col1    (r_col1),
        .i_col2    (r_col2),
        .i_side    (n_tex),
        .o_valid   (x_valid),
        .o_cx      (x_cx),
        .o_cy      (x_cy),
        .o_cz      (x_cz),
        .o_side    (x_tex)
    );

    vpp_numer #(.SW(TSW)) u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .i_cx    (x_cx),
        .i_cy    (x_cy),
        .i_cz    (x_cz),
        .i_fs    (r_fs),
        .i_side  (x_tex),
        .o_valid (m_valid),
        .o_ax    (m_ax),
        .o_ay    (m_ay),
        .o_b     (m_b),
        .o_sgn   (m_sgn),
        .o_side  (m_tex)
    );

    assign d_side_in.tex = m_tex;
    assign d_side_in.sgn = m_sgn;

    vpp_div #(.QW(vpp_pkg::QW), .BW(vpp_pkg::BW), .SW(DSW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .i_ax    (m_ax),
        .i_ay    (m_ay),
        .i_b     (m_b),
        .i_side  (d_side_in),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_side  (d_side_out)
    );

    // Apply sign, add the canvas centre, saturate
    always_comb begin
        n_magx = d_side_out.sgn.clamp_x ? '1 : d_qx;
        n_magy = d_side_out.sgn.clamp_y ? '1 : d_qy;
        n_sumx = (d_side_out.sgn.qs_x ? -$signed({3'b000, n_magx}) : $signed({3'b000, n_magx}))
                 + $signed({16'd0, 1'b0, r_width[11:1], 8'd0});
        n_sumy = (d_side_out.sgn.qs_y ? -$signed({3'b000, n_magy}) : $signed({3'b000, n_magy}))
                 + $signed({16'd0, 1'b0, r_height[11:1], 8'd0});
        if (d_side_out.sgn.zero) begin
            n_sx = d_side_out.sgn.neg_x ? vpp_pkg::SAT_MIN : vpp_pkg::SAT_MAX;
            n_sy = d_side_out.sgn.neg_y ? vpp_pkg::SAT_MIN : vpp_pkg::SAT_MAX;
        end else begin
            n_sx = vpp_pkg::sat32(n_sumx);
            n_sy = vpp_pkg::sat32(n_sumy);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_depth <= 32'(d_side_out.sgn.z);
        r_tu    <= d_side_out.tex.u;
        r_tv    <= d_side_out.tex.v;
        r_tvld  <= d_side_out.tex.tv;
        r_err   <= d_side_out.sgn.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_screen_x     = r_sx;
    assign o_screen_y     = r_sy;
    assign o_depth        = r_depth;
    assign o_tex_out_u    = r_tu;
    assign o_tex_out_v    = r_tv;
    assign o_tex_valid    = r_tvld;
    assign o_divide_error = r_err;

    // A zero depth saturates both screen coordinates
    a_err_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |->
            ((o_screen_x == vpp_pkg::SAT_MIN || o_screen_x == vpp_pkg::SAT_MAX) &&
             (o_screen_y == vpp_pkg::SAT_MIN || o_screen_y == vpp_pkg::SAT_MAX)))
        else $error("divide error without saturated screen coordinates");

    // Error flag and depth travel together through the divider
    a_err_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_divide_error == (o_depth == 32'sd0)))
        else $error("divide error flag disagrees with depth");

    // Texture flag matches the delivered texture word
    a_tex_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tex_valid == (!o_tex_out_u[15] && !o_tex_out_v[15])))
        else $error("texture valid flag out of step with texture word");
endmodule
`default_nettype wire
